@@ rtl/sfrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_pkg
// Shared types and constants of the serial frame receive parser.
// ----------------------------------------------------------------------------
package sfrp_pkg;

    localparam int FRAME_DEPTH     = 256;
    localparam int ADDR_W          = $clog2(FRAME_DEPTH);
    localparam int HEADER_INFO_LEN = 7;
    localparam int TRAILER_LEN     = 2;
    localparam int RES_DEPTH       = 4;
    localparam int RES_PTR_W       = $clog2(RES_DEPTH);
    localparam int RES_CNT_W       = $clog2(RES_DEPTH + 1);

    // Status codes
    localparam logic [2:0] ST_PARSING = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_SHORT   = 3'd2;
    localparam logic [2:0] ST_LONG    = 3'd3;
    localparam logic [2:0] ST_CSUM    = 3'd4;
    localparam logic [2:0] ST_SUCC    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_HEAD_FIRST  = 2'd0;
    localparam logic [1:0] REG_HEAD_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LEN     = 2'd2;

    localparam logic [7:0] HEAD_FIRST_RST  = 8'd85;
    localparam logic [7:0] HEAD_SECOND_RST = 8'd170;
    localparam logic [7:0] MAX_LEN_RST     = 8'd255;

    typedef struct packed {
        logic [7:0] head_first;
        logic [7:0] head_second;
        logic [7:0] max_len;
    } sfrp_cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  position;
        logic [15:0] frame_length;
        logic [15:0] frame_version;
        logic [7:0]  frame_option;
        logic        last_of_run;
    } sfrp_result_t;

    typedef struct packed {
        logic         push0;
        logic         push1;
        sfrp_result_t res0;
        sfrp_result_t res1;
    } sfrp_push_t;

endpackage

@@ rtl/sfrp_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_byte_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface sfrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sfrp_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_result_if
// Parse status result channel.
// ----------------------------------------------------------------------------
interface sfrp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  position;
    logic [15:0] frame_length;
    logic [15:0] frame_version;
    logic [7:0]  frame_option;
    logic        last_of_run;

    modport source (
        output valid, output status, output position, output frame_length,
        output frame_version, output frame_option, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input status, input position, input frame_length,
        input frame_version, input frame_option, input last_of_run,
        output ready
    );
endinterface

@@ rtl/sfrp_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface sfrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sfrp_frame_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_frame_store
// Frame byte memory, one write port and one registered read port with
// write-first forwarding.
// ----------------------------------------------------------------------------
module sfrp_frame_store
    import sfrp_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [FRAME_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sfrp_parse_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_parse_core
// Per-byte frame parse: header hunt, header fields, running sum, length and
// trailer checks. Stores frame bytes and reads back the trailer low byte.
// ----------------------------------------------------------------------------
module sfrp_parse_core
    import sfrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  sfrp_cfg_t  cfg,
    output sfrp_push_t push
);

    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] ver_reg, ver_next;
    logic [7:0]  opt_reg, opt_next;

    logic        store_en;
    logic [7:0]  store_idx;
    logic        v0, v1;
    logic [2:0]  s0, s1;
    logic [7:0]  p0, p1;
    logic [7:0]  cnt_inc;
    logic [15:0] trailer;
    logic [7:0]  low_byte;
    logic        ram_wr_en;
    logic [7:0]  rd_cnt;

    assign cnt_inc = cnt_reg + 8'd1;
    assign trailer = {rx_byte, low_byte};

    // Decide what this byte does, from registered state only
    always_comb
    begin
        store_en  = 1'b0;
        store_idx = cnt_reg;
        cnt_next  = cnt_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        s0 = ST_PARSING;
        s1 = ST_PARSING;
        p0 = 8'd0;
        p1 = 8'd0;
        if (accept)
        begin
            if (cnt_reg == 8'd0)
            begin
                v0 = 1'b1;
                if (rx_byte != cfg.head_first)
                begin
                    s0 = ST_INVALID;
                end
                else
                begin
                    store_en = 1'b1;
                    cnt_next = cnt_inc;
                    p0       = cnt_inc;
                end
            end
            else if (cnt_reg == 8'd1)
            begin
                v0 = 1'b1;
                if (rx_byte == cfg.head_second)
                begin
                    store_en = 1'b1;
                    cnt_next = cnt_inc;
                    p0       = cnt_inc;
                end
                else
                begin
                    s0       = ST_INVALID;
                    p0       = 8'd1;
                    cnt_next = 8'd0;
                    // restart the hunt with this byte as a new first byte
                    if (rx_byte == cfg.head_first)
                    begin
                        store_en  = 1'b1;
                        store_idx = 8'd0;
                        cnt_next  = 8'd1;
                        v1        = 1'b1;
                        p1        = 8'd1;
                    end
                end
            end
            else if (cnt_reg < 8'(HEADER_INFO_LEN - 1))
            begin
                store_en = 1'b1;
                cnt_next = cnt_inc;
                v0       = 1'b1;
                p0       = cnt_inc;
            end
            else if (cnt_reg == 8'(HEADER_INFO_LEN - 1))
            begin
                store_en = 1'b1;
                cnt_next = cnt_inc;
                p0       = cnt_inc;
                if (len_reg <= 16'(HEADER_INFO_LEN + TRAILER_LEN))
                begin
                    v0       = 1'b1;
                    s0       = ST_SHORT;
                    cnt_next = 8'd0;
                end
                else if ((len_reg > {8'd0, cfg.max_len})
                         || ({1'b0, len_reg} > 17'(FRAME_DEPTH)))
                begin
                    v0       = 1'b1;
                    s0       = ST_LONG;
                    cnt_next = 8'd0;
                end
            end
            else
            begin
                store_en = 1'b1;
                v0       = 1'b1;
                p0       = cnt_inc;
                if (16'(cnt_inc) < len_reg)
                begin
                    cnt_next = cnt_inc;
                end
                else
                begin
                    // last byte is never summed, so the held sum is final
                    s0       = (trailer == sum_reg) ? ST_SUCC : ST_CSUM;
                    cnt_next = 8'd0;
                end
            end
        end
    end

    // Effect of storing one byte at store_idx
    always_comb
    begin
        sum_next = sum_reg;
        len_next = len_reg;
        ver_next = ver_reg;
        opt_next = opt_reg;
        if (store_en)
        begin
            if (store_idx == 8'd0)
            begin
                sum_next = {8'd0, rx_byte};
            end
            else if ((store_idx < 8'(HEADER_INFO_LEN))
                     || ((16'(store_idx) + 16'(TRAILER_LEN)) < len_reg))
            begin
                sum_next = sum_reg + {8'd0, rx_byte};
            end
            case (store_idx)
                8'd2:    len_next = {len_reg[15:8], rx_byte};
                8'd3:    len_next = {rx_byte, len_reg[7:0]};
                8'd4:    ver_next = {ver_reg[15:8], rx_byte};
                8'd5:    ver_next = {rx_byte, ver_reg[7:0]};
                8'd6:    opt_next = rx_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 8'd0;
            sum_reg <= 16'd0;
            len_reg <= 16'd0;
            ver_reg <= 16'd0;
            opt_reg <= 8'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            len_reg <= len_next;
            ver_reg <= ver_next;
            opt_reg <= opt_next;
        end
    end

    // Keep the byte just below the count on the read port
    assign rd_cnt    = cnt_next - 8'd1;
    assign ram_wr_en = store_en && ({1'b0, store_idx} < 9'(FRAME_DEPTH));

    sfrp_frame_store u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (store_idx[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_addr (rd_cnt[ADDR_W-1:0]),
        .rd_data (low_byte)
    );

    always_comb
    begin
        push.push0 = v0;
        push.push1 = v1;

        push.res0.status        = s0;
        push.res0.position      = p0;
        push.res0.frame_length  = (p0 >= 8'(HEADER_INFO_LEN)) ? len_next : 16'd0;
        push.res0.frame_version = (p0 >= 8'(HEADER_INFO_LEN)) ? ver_next : 16'd0;
        push.res0.frame_option  = (p0 >= 8'(HEADER_INFO_LEN)) ? opt_next : 8'd0;
        push.res0.last_of_run   = !v1;

        push.res1.status        = s1;
        push.res1.position      = p1;
        push.res1.frame_length  = (p1 >= 8'(HEADER_INFO_LEN)) ? len_next : 16'd0;
        push.res1.frame_version = (p1 >= 8'(HEADER_INFO_LEN)) ? ver_next : 16'd0;
        push.res1.frame_option  = (p1 >= 8'(HEADER_INFO_LEN)) ? opt_next : 8'd0;
        push.res1.last_of_run   = 1'b1;
    end

endmodule

@@ rtl/sfrp_result_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_result_fifo
// Result queue taking up to two entries a cycle and giving one.
// ----------------------------------------------------------------------------
module sfrp_result_fifo
    import sfrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  sfrp_push_t   push,
    output logic         room,
    output logic         head_valid,
    input  logic         head_pop,
    output sfrp_result_t head
);

    sfrp_result_t              entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [RES_PTR_W-1:0]      wr_ptr_inc;
    logic [RES_CNT_W-1:0]      n_push;
    logic                      pop;

    assign room       = cnt_reg <= RES_CNT_W'(RES_DEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && head_pop;
    assign wr_ptr_inc = wr_ptr_reg + RES_PTR_W'(1);

    always_comb
    begin
        n_push      = RES_CNT_W'(push.push0) + RES_CNT_W'(push.push1);
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + RES_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + n_push - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            entry_reg[wr_ptr_inc] <= push.res1;
        end
    end

endmodule

@@ rtl/serial_frame_receive_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receive_parser
// Byte stream frame parser: header hunt, length/version/option fields,
// 16-bit additive checksum against a little-endian trailer.
// ----------------------------------------------------------------------------
//  Channel  Dir   Payload                                         Transfer
//  rx       in    rx_byte                                         valid & ready
//  report   out   status, position, frame_length, frame_version,  valid & ready
//                 frame_option, last_of_run
//  cfg      in    index, data (head_first, head_second, max_len)  valid & ready
//
//  One byte per cycle; its zero, one or two results enter a four-entry
//  result queue in the same cycle and leave one per cycle while report.ready is high.
//  rx.ready is low while fewer than two queue slots are free.
//  The running sum and header fields update in the accepting cycle; the
//  trailer low byte comes back from the frame memory read port.
//  Reset clears the parse state and loads the register defaults; the frame
//  memory is not cleared. cfg.ready is always high.
// ----------------------------------------------------------------------------
module serial_frame_receive_parser
    import sfrp_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    sfrp_byte_if.sink     rx,
    sfrp_result_if.source report,
    sfrp_cfg_if.sink      cfg
);

    sfrp_cfg_t    cfg_reg;
    sfrp_push_t   push;
    sfrp_result_t head;
    logic         room;
    logic         accept;

    assign cfg.ready = 1'b1;
    assign rx.ready  = room;
    assign accept    = rx.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_first  <= HEAD_FIRST_RST;
            cfg_reg.head_second <= HEAD_SECOND_RST;
            cfg_reg.max_len     <= MAX_LEN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEAD_FIRST:  cfg_reg.head_first  <= cfg.data;
                REG_HEAD_SECOND: cfg_reg.head_second <= cfg.data;
                REG_MAX_LEN:     cfg_reg.max_len     <= cfg.data;
                default:         ;
            endcase
        end
    end

    sfrp_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg_reg),
        .push    (push)
    );

    sfrp_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (report.valid),
        .head_pop   (report.ready),
        .head       (head)
    );

    assign report.status        = head.status;
    assign report.position      = head.position;
    assign report.frame_length  = head.frame_length;
    assign report.frame_version = head.frame_version;
    assign report.frame_option  = head.frame_option;
    assign report.last_of_run   = head.last_of_run;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial frame receive parser. A queue of bytes
// (directed header/length cases, then mostly well-formed frames with random
// content mixed with bad checksums, truncated headers and line noise) feeds
// a handshake driver. A monitor predicts the status reports of every byte
// transfer and checks each report transfer against the oldest prediction.
// Register settings change between phases after a drain, with a frame open.
// ----------------------------------------------------------------------------
module tb_top;

    import sfrp_pkg::*;

    localparam int PHASE_ITEMS   = 250;
    localparam int PHASE_COUNT   = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int IDLE_PCT      = 26;

    logic clk = 1'b0;
    logic rst_n;

    sfrp_byte_if   byte_ch ();
    sfrp_result_if report_ch ();
    sfrp_cfg_if    cfg_ch ();

    serial_frame_receive_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (byte_ch),
        .report (report_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // Stimulus and expectations
    logic [7:0]   tx_bytes [$];
    sfrp_result_t pending_reports [$];
    int           queued_total = 0;
    int           rx_count     = 0;
    int           errors       = 0;
    logic         steady       = 1'b0;
    logic         hold_rx      = 1'b0;

    // Register values the generator builds frames for
    logic [7:0] gen_head_first  = HEAD_FIRST_RST;
    logic [7:0] gen_head_second = HEAD_SECOND_RST;
    logic [7:0] gen_max_len     = MAX_LEN_RST;

    // Predicted parser state and registers
    logic [7:0]  reg_head_first  = HEAD_FIRST_RST;
    logic [7:0]  reg_head_second = HEAD_SECOND_RST;
    logic [7:0]  reg_max_len     = MAX_LEN_RST;
    logic [7:0]  parse_count     = '0;
    logic [15:0] parse_sum       = '0;
    logic [15:0] parse_len       = '0;
    logic [15:0] parse_ver       = '0;
    logic [7:0]  parse_opt       = '0;
    logic [7:0]  parse_prev      = '0;

    function automatic sfrp_result_t make_report(input logic [2:0] st, input logic [7:0] pos);
        sfrp_result_t r;
        r = '0;
        r.status   = st;
        r.position = pos;
        if (pos >= HEADER_INFO_LEN)
        begin
            r.frame_length  = parse_len;
            r.frame_version = parse_ver;
            r.frame_option  = parse_opt;
        end
        return r;
    endfunction

    // Store one byte at the current count and fold it into the header fields and sum
    function automatic void store_rx(input logic [7:0] b);
        logic [7:0] idx;
        idx = parse_count;
        if (idx == 8'd0)
            parse_sum = {8'h00, b};
        else if (idx < HEADER_INFO_LEN || int'(idx) + TRAILER_LEN < int'(parse_len))
            parse_sum = parse_sum + {8'h00, b};
        case (idx)
            8'd2: parse_len[7:0]  = b;
            8'd3: parse_len[15:8] = b;
            8'd4: parse_ver[7:0]  = b;
            8'd5: parse_ver[15:8] = b;
            8'd6: parse_opt       = b;
            default: ;
        endcase
        parse_prev  = b;
        parse_count = idx + 8'd1;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        sfrp_result_t r [2];
        int           n;
        logic [7:0]   low;
        logic [15:0]  trailer;
        n = 0;
        if (parse_count == 8'd0)
        begin
            if (b != reg_head_first)
            begin
                r[n] = make_report(ST_INVALID, 8'd0);
                n++;
            end
            else
            begin
                store_rx(b);
                r[n] = make_report(ST_PARSING, parse_count);
                n++;
            end
        end
        else if (parse_count == 8'd1)
        begin
            if (b == reg_head_second)
            begin
                store_rx(b);
                r[n] = make_report(ST_PARSING, parse_count);
                n++;
            end
            else
            begin
                r[n] = make_report(ST_INVALID, 8'd1);
                n++;
                parse_count = '0;
                // a repeated first header byte restarts the hunt
                if (b == reg_head_first)
                begin
                    store_rx(b);
                    r[n] = make_report(ST_PARSING, parse_count);
                    n++;
                end
            end
        end
        else if (parse_count < HEADER_INFO_LEN - 1)
        begin
            store_rx(b);
            r[n] = make_report(ST_PARSING, parse_count);
            n++;
        end
        else if (parse_count == HEADER_INFO_LEN - 1)
        begin
            store_rx(b);
            if (parse_len <= HEADER_INFO_LEN + TRAILER_LEN)
            begin
                r[n] = make_report(ST_SHORT, parse_count);
                n++;
                parse_count = '0;
            end
            else if (parse_len > reg_max_len || parse_len > FRAME_DEPTH)
            begin
                r[n] = make_report(ST_LONG, parse_count);
                n++;
                parse_count = '0;
            end
        end
        else
        begin
            low = parse_prev;
            store_rx(b);
            if ({8'h00, parse_count} < parse_len)
            begin
                r[n] = make_report(ST_PARSING, parse_count);
                n++;
            end
            else
            begin
                trailer = {b, low};
                r[n] = make_report((trailer == parse_sum) ? ST_SUCC : ST_CSUM, parse_count);
                n++;
                parse_count = '0;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                r[i].last_of_run = 1'b1;
            pending_reports.push_back(r[i]);
        end
    endfunction

    function automatic void flag_error(input string what, input sfrp_result_t want,
                                       input sfrp_result_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: exp st=%0d pos=%0d len=%h ver=%h opt=%h last=%b",
                     $realtime, what, want.status, want.position, want.frame_length,
                     want.frame_version, want.frame_option, want.last_of_run,
                     " / got st=%0d pos=%0d len=%h ver=%h opt=%h last=%b",
                     got.status, got.position, got.frame_length, got.frame_version,
                     got.frame_option, got.last_of_run);
    endfunction

    // Byte driver: hold valid and data until the transfer
    always @(posedge clk)
    begin
        if (rst_n && (!byte_ch.valid || byte_ch.ready))
        begin
            if (tx_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                byte_ch.valid   <= 1'b1;
                byte_ch.rx_byte <= tx_bytes.pop_front();
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // Monitor: track register writes, predict byte transfers, check report transfers
    always @(posedge clk)
    begin : monitor
        sfrp_result_t got;
        sfrp_result_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_HEAD_FIRST:  reg_head_first  = cfg_ch.data;
                    REG_HEAD_SECOND: reg_head_second = cfg_ch.data;
                    REG_MAX_LEN:     reg_max_len     = cfg_ch.data;
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                parse_byte(byte_ch.rx_byte);
                rx_count <= rx_count + 1;
            end
            if (report_ch.valid && report_ch.ready)
            begin
                got.status        = report_ch.status;
                got.position      = report_ch.position;
                got.frame_length  = report_ch.frame_length;
                got.frame_version = report_ch.frame_version;
                got.frame_option  = report_ch.frame_option;
                got.last_of_run   = report_ch.last_of_run;
                if (pending_reports.size() == 0)
                    flag_error("unexpected report", '0, got);
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.status !== want.status || got.position !== want.position
                        || got.frame_length !== want.frame_length
                        || got.frame_version !== want.frame_version
                        || got.frame_option !== want.frame_option
                        || got.last_of_run !== want.last_of_run)
                        flag_error("report mismatch", want, got);
                end
            end
            report_ch.ready <= !hold_rx && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Back-pressure: stall the report side long enough to fill the result queue
    initial
    begin
        wait (rx_count >= HOLD_AFTER);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        queued_total++;
    endfunction

    function automatic int good_len();
        int hi;
        hi = (gen_max_len > 40 && $urandom_range(9) != 0) ? 40 : int'(gen_max_len);
        return $urandom_range(hi, 10);
    endfunction

    // Build one frame for the current header bytes; only lengths that pass get a body
    task automatic queue_frame(input int flen, input logic [15:0] ver, input logic [7:0] opt,
                               input bit corrupt, input int cut);
        logic [7:0]  fb [$];
        logic [15:0] sum;
        fb.push_back(gen_head_first);
        fb.push_back(gen_head_second);
        fb.push_back(flen[7:0]);
        fb.push_back(flen[15:8]);
        fb.push_back(ver[7:0]);
        fb.push_back(ver[15:8]);
        fb.push_back(opt);
        if (flen > HEADER_INFO_LEN + TRAILER_LEN && flen <= gen_max_len)
        begin
            for (int i = HEADER_INFO_LEN; i < flen - TRAILER_LEN; i++)
                fb.push_back(8'($urandom));
            sum = '0;
            foreach (fb[i])
                sum = sum + {8'h00, fb[i]};
            if (corrupt)
                sum = sum ^ 16'($urandom_range(65535, 1));
            fb.push_back(sum[7:0]);
            fb.push_back(sum[15:8]);
        end
        if (cut > 0 && cut < fb.size())
            fb = fb[0:cut-1];
        foreach (fb[i])
            push_byte(fb[i]);
    endtask

    // Wait until every byte is out and every report is in, then let the parser settle
    task automatic drain();
        int waited;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while ((tx_bytes.size() != 0 || byte_ch.valid || pending_reports.size() != 0)
               && waited < DRAIN_LIMIT);
        if (pending_reports.size() != 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t %0d reports never arrived", $realtime, pending_reports.size());
            pending_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] head_a, input logic [7:0] head_b,
                            input logic [7:0] max_len);
        drain();
        write_reg(REG_HEAD_FIRST, head_a);
        write_reg(REG_HEAD_SECOND, head_b);
        write_reg(REG_MAX_LEN, max_len);
        gen_head_first  = head_a;
        gen_head_second = head_b;
        gen_max_len     = max_len;
    endtask

    initial
    begin
        logic [7:0] head;
        int         stop_at;
        int         pick;
        int         flen;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        report_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_HEAD_FIRST;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults: bad first byte, bad second byte, restart, short length
        push_byte(8'h00);
        push_byte(HEAD_FIRST_RST);
        push_byte(8'h13);
        push_byte(HEAD_FIRST_RST);
        queue_frame(9, 16'h1234, 8'hFF, 1'b0, 0);

        // Extreme registers: longest length field, then the shortest legal frame
        set_regs(8'hFF, 8'h00, 8'd10);
        queue_frame(65535, 16'h0000, 8'h00, 1'b0, 0);
        queue_frame(10, 16'h0201, 8'h80, 1'b0, 0);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: set_regs(HEAD_FIRST_RST, HEAD_SECOND_RST, MAX_LEN_RST);
                1: set_regs(8'h00, 8'hFF, 8'd10);
                2:
                begin
                    head = 8'($urandom);
                    set_regs(head, head, 8'($urandom_range(255, 10)));
                end
                default: set_regs(8'($urandom), 8'($urandom), 8'($urandom_range(255, 10)));
            endcase
            steady <= (ph == 2);
            // complete the header of the frame left open across the register change
            if (ph > 0)
                repeat (3) push_byte(8'($urandom));
            stop_at = queued_total + PHASE_ITEMS;
            while (queued_total < stop_at)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    queue_frame(good_len(), 16'($urandom), 8'($urandom), 1'b0, 0);
                else if (pick < 70)
                    queue_frame(good_len(), 16'($urandom), 8'($urandom), 1'b1, 0);
                else if (pick < 75)
                    queue_frame($urandom_range(9, 0), 16'($urandom), 8'($urandom), 1'b0, 0);
                else if (pick < 80)
                begin
                    case ($urandom_range(3))
                        0: flen = int'(gen_max_len) + 1;
                        1: flen = FRAME_DEPTH;
                        2: flen = 65535;
                        default: flen = $urandom_range(65535, int'(gen_max_len) + 1);
                    endcase
                    queue_frame(flen, 16'($urandom), 8'($urandom), 1'b0, 0);
                end
                else if (pick < 88)
                    queue_frame(good_len(), 16'($urandom), 8'($urandom), 1'b0,
                                $urandom_range(HEADER_INFO_LEN - 1, 1));
                else
                    repeat ($urandom_range(4, 1))
                        push_byte($urandom_range(1) ? gen_head_first : 8'($urandom));
            end
            // leave a frame open up to its length field
            if (ph < PHASE_COUNT - 1)
            begin
                push_byte(gen_head_first);
                push_byte(gen_head_second);
                push_byte(8'($urandom_range(40, 10)));
                push_byte(8'h00);
            end
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
